// ===== rtl/htwd_pkg.sv =====
// Shared constants, field layout and control/status types of the tree-walk decoder.
package htwd_pkg;

    localparam int NODE_COUNT_DEF = 512;
    localparam int BITS_PER_BYTE  = 8;

    localparam int IDX_W   = 9;
    localparam int SYM_W   = 8;
    localparam int LVB_W   = 4;
    localparam int NODE_W  = 2 * IDX_W + 1 + SYM_W;
    localparam int BIT_CNT_W = $clog2(BITS_PER_BYTE + 1);

    // node word layout: left, right, leaf flag, symbol
    localparam int ND_LEFT_LO  = 0;
    localparam int ND_RIGHT_LO = IDX_W;
    localparam int ND_LEAF     = 2 * IDX_W;
    localparam int ND_SYM_LO   = 2 * IDX_W + 1;

    // input tdata layout
    localparam int SD_IDX_LO   = 0;
    localparam int SD_LEFT_LO  = SD_IDX_LO + IDX_W;
    localparam int SD_RIGHT_LO = SD_LEFT_LO + IDX_W;
    localparam int SD_LEAF     = SD_RIGHT_LO + IDX_W;
    localparam int SD_SYM_LO   = SD_LEAF + 1;
    localparam int SD_BYTE_LO  = SD_SYM_LO + SYM_W;
    localparam int SD_FIRST    = SD_BYTE_LO + BITS_PER_BYTE;
    localparam int S_TDATA_W   = ((SD_FIRST + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W   = SYM_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = IDX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_VALID = 1'b1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [LVB_W-1:0] LVB_RESET = LVB_W'(BITS_PER_BYTE);

    typedef struct packed {
        logic load;
        logic start;
        logic fetch;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic is_decode;
        logic start_ok;
        logic walk_end;
        logic stall;
        logic pend_valid;
        logic slot_free;
    } t_sts;

endpackage

// ===== rtl/huffman_tree_walk_decoder_unit.sv =====
// Top level of the Huffman tree-walk decoder: sequencer plus datapath.
//
// Slave stream: tuser selects the item kind (0 loads one tree node, 1 decodes
// one compressed byte), tlast marks the final byte of a stream. A load writes
// node storage in the cycle it is accepted. A decode byte is walked MSB first,
// one tree step per cycle; each leaf reached yields one result item on the
// master stream: tdata is the symbol, tlast marks the last symbol of the byte,
// tuser marks the symbol that ends the stream at last_valid_bits.
// Tree nodes must be loaded and root_node / last_valid_bits written through the
// configuration port while no byte is in flight.
// A decode byte passes through acceptance, one node fetch, up to eight tree steps
// plus one leaf check, and one flush of the held-back symbol. Each tree step is one
// read of the node memory, which has two read ports (next node and root node). A
// byte on a stopped stream, or a load, is taken in the idle phase alone.
// A result is held back one step so that last-of-byte can be marked; when the
// receiver stalls, the walk holds until the output register frees. The slave
// side is ready only between bytes.
// Reset clears the walk position, the stop flag, root_node to 0 and
// last_valid_bits to 8; node storage is left as it is and must be loaded.
module huffman_tree_walk_decoder_unit import htwd_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // node_index[8:0], left_child[17:9], right_child[26:18], is_leaf[27],
    // leaf_symbol[35:28], data_byte[43:36], first_byte[44], zero pad[47:45]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // opcode
    input  logic                  i_s_tuser,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // symbol[7:0]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // end_of_stream
    output logic                  o_m_tuser,
    output logic                  o_m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    htwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    htwd_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ===== rtl/htwd_ctrl.sv =====
// Sequencer of the tree-walk decoder: idle, fetch, walk and flush phases.
module htwd_ctrl import htwd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = o_s_tready && i_s_tvalid;

    always_comb begin
        o_cmd.load  = accept && (i_sts.is_decode == OP_LOAD);
        o_cmd.start = accept && (i_sts.is_decode == OP_DECODE);
        o_cmd.fetch = (r_state == ST_FETCH);
        o_cmd.step  = (r_state == ST_WALK) && !i_sts.stall;
        o_cmd.flush = (r_state == ST_FLUSH) && i_sts.pend_valid && i_sts.slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start && i_sts.start_ok) n_state = ST_FETCH;
            end
            ST_FETCH: n_state = ST_WALK;
            ST_WALK: begin
                if (o_cmd.step && i_sts.walk_end) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!i_sts.pend_valid || i_sts.slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/htwd_datapath.sv =====
// Node memory, walk registers, pending symbol and output register of the decoder.
module htwd_datapath import htwd_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tuser,
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic                  o_m_tlast,
    output logic                  o_m_tuser,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IDX_W+1:0] ext;
        ext = {2'b00, idx};
        return ext[ADDR_W-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return int'(idx) < NODE_COUNT;
    endfunction

    logic [NODE_W-1:0] mem [0:NODE_COUNT-1];

    logic [IDX_W-1:0]         r_root;
    logic [LVB_W-1:0]         r_lvb;
    logic [IDX_W-1:0]         r_cur_idx;
    logic                     r_stopped;
    logic [BITS_PER_BYTE-1:0] r_byte;
    logic                     r_last;
    logic [BIT_CNT_W-1:0]     r_bit;
    logic [NODE_W-1:0]        r_rd_a;
    logic [NODE_W-1:0]        r_rd_b;
    logic                     r_pend_valid;
    logic [SYM_W-1:0]         r_pend_sym;
    logic                     r_pend_eos;
    logic                     r_out_valid;
    logic [SYM_W-1:0]         r_out_sym;
    logic                     r_out_last;
    logic                     r_out_eos;

    logic [IDX_W-1:0]  in_idx;
    logic [NODE_W-1:0] in_node;
    logic              in_first;
    logic              nd_leaf;
    logic              stop;
    logic [IDX_W-1:0]  eff_idx;
    logic [NODE_W-1:0] eff_node;
    logic [IDX_W-1:0]  nxt;
    logic              walk_end;
    logic              slot_free;
    logic              push;
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_en;

    assign in_idx   = i_s_tdata[SD_IDX_LO +: IDX_W];
    assign in_first = i_s_tdata[SD_FIRST];
    assign in_node  = {i_s_tdata[SD_SYM_LO +: SYM_W], i_s_tdata[SD_LEAF],
                       i_s_tdata[SD_RIGHT_LO +: IDX_W], i_s_tdata[SD_LEFT_LO +: IDX_W]};

    // result of the previous tree step sits in r_rd_a; node of the root in r_rd_b
    assign nd_leaf  = (r_bit != '0) && r_rd_a[ND_LEAF];
    assign stop     = nd_leaf && r_last && (r_bit == r_lvb);
    assign eff_idx  = nd_leaf ? r_root : r_cur_idx;
    assign eff_node = nd_leaf ? r_rd_b : r_rd_a;
    assign walk_end = stop || (r_bit == BIT_CNT_W'(BITS_PER_BYTE));

    always_comb begin
        // a leaf root emits its symbol on every bit without moving
        if ((eff_idx == r_root) && eff_node[ND_LEAF]) begin
            nxt = eff_idx;
        end else if (r_byte[BITS_PER_BYTE-1]) begin
            nxt = eff_node[ND_RIGHT_LO +: IDX_W];
        end else begin
            nxt = eff_node[ND_LEFT_LO +: IDX_W];
        end
    end

    assign slot_free = !r_out_valid || i_m_tready;
    assign push      = (i_cmd.step && nd_leaf && r_pend_valid) || i_cmd.flush;
    assign rd_idx    = i_cmd.fetch ? r_cur_idx : nxt;
    assign rd_en     = i_cmd.fetch || i_cmd.step;

    always_comb begin
        o_sts.is_decode  = i_s_tuser;
        o_sts.start_ok   = in_first || !r_stopped;
        o_sts.walk_end   = walk_end;
        o_sts.stall      = nd_leaf && r_pend_valid && !slot_free;
        o_sts.pend_valid = r_pend_valid;
        o_sts.slot_free  = slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_range(in_idx)) begin
            mem[to_addr(in_idx)] <= in_node;
        end
        if (rd_en) begin
            r_rd_a <= in_range(rd_idx) ? mem[to_addr(rd_idx)] : '0;
            r_rd_b <= in_range(r_root) ? mem[to_addr(r_root)] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
            r_lvb  <= LVB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROOT_NODE:  r_root <= i_cfg_wdata[IDX_W-1:0];
                CFG_LAST_VALID: r_lvb  <= i_cfg_wdata[LVB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_byte <= i_s_tdata[SD_BYTE_LO +: BITS_PER_BYTE];
            r_last <= i_s_tlast;
        end else if (i_cmd.step && !walk_end) begin
            r_byte <= {r_byte[BITS_PER_BYTE-2:0], 1'b0};
        end
        if (push) begin
            r_out_sym  <= r_pend_sym;
            r_out_eos  <= r_pend_eos;
            r_out_last <= i_cmd.flush;
        end
        if (i_cmd.step && nd_leaf) begin
            r_pend_sym <= r_rd_a[ND_SYM_LO +: SYM_W];
            r_pend_eos <= stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_idx    <= '0;
            r_stopped    <= 1'b0;
            r_bit        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_bit <= '0;
                if (in_first) begin
                    r_cur_idx <= r_root;
                    r_stopped <= 1'b0;
                end
            end else if (i_cmd.step) begin
                if (walk_end) begin
                    r_cur_idx <= eff_idx;
                end else begin
                    r_cur_idx <= nxt;
                    r_bit     <= r_bit + 1'b1;
                end
                if (stop) r_stopped <= 1'b1;
            end

            if (i_cmd.step && nd_leaf) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end

            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_sym;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_eos;

    a_push_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> slot_free)
        else $error("result pushed into an occupied output register");

    a_bit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BIT_CNT_W'(BITS_PER_BYTE))
        else $error("bit counter ran past the byte");

    a_stop_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && stop) |=> r_stopped)
        else $error("stream end did not set the stop flag");

    a_eos_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eos) |-> r_out_last)
        else $error("end-of-stream symbol not marked last of its byte");

    a_flush_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_pend_valid && !(i_cmd.step)))
        else $error("flush without a pending symbol");

endmodule
